### src/hkrt_pkg.sv
// Package: shared word types, operation and status codes, size constants for the report tracker.
package hkrt_pkg;

	localparam int KEY_SLOTS_DEF = 6;
	localparam int MAP_DEPTH_DEF = 128;
	localparam int OUT_SLOTS     = 6;

	localparam logic [1:0] FUNC_PRESS   = 2'd0;
	localparam logic [1:0] FUNC_RELEASE = 2'd1;
	localparam logic [1:0] FUNC_REL_ALL = 2'd2;
	localparam logic [1:0] FUNC_MAP_WR  = 2'd3;

	localparam logic [1:0] STAT_SENT     = 2'd0;
	localparam logic [1:0] STAT_UNMAPPED = 2'd1;
	localparam logic [1:0] STAT_NO_SLOT  = 2'd2;

	localparam logic [7:0] RAW_BASE   = 8'd136;
	localparam logic [7:0] MOD_BASE   = 8'd128;
	localparam logic [7:0] LEFT_SHIFT = 8'h02;
	localparam logic [7:0] USAGE_MASK = 8'h7F;
	localparam logic [7:0] SHIFT_FLAG = 8'h80;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] key_code;
		logic [6:0] map_index;
		logic [7:0] map_value;
	} hkrt_cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] modifier_bits;
		logic [7:0] slot0;
		logic [7:0] slot1;
		logic [7:0] slot2;
		logic [7:0] slot3;
		logic [7:0] slot4;
		logic [7:0] slot5;
	} hkrt_rpt_t;

endpackage

### src/hkrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hkrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/hid_keyboard_report_tracker.sv
// Top level: boot-keyboard report tracker with map RAM and a one-comparator slot sequencer.
//
//  channel  | handshake          | word        | direction
//  ---------+--------------------+-------------+----------
//  command  | start high, busy lo| cmd         | in
//  report   | rpt_valid strobe   | rpt         | out
//
// Map write: taken without leaving idle, busy stays low, no report.
// Press/release: a decode state, then the shared comparator walks the slots one per cycle
// (press: duplicate scan, then free-slot scan; release: all slots), then an emit state loads
// the report; release-all and unmapped keys go from decode straight to emit. rpt_valid
// rises in the same cycle as busy drops.
// Reset clears the report, the map valid bits and the sequencer; no clearing pass.
// The receiver cannot stall: rpt_valid is high for exactly one cycle.
module hid_keyboard_report_tracker
	import hkrt_pkg::*;
#(
	parameter int KEY_SLOTS = KEY_SLOTS_DEF,
	parameter int MAP_DEPTH = MAP_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  hkrt_cmd_t cmd,
	output logic      rpt_valid,
	output hkrt_rpt_t rpt
);

	localparam int IDX_W  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int MAP_AW = $clog2(MAP_DEPTH);
	localparam int EXT_N  = (KEY_SLOTS > OUT_SLOTS) ? KEY_SLOTS : OUT_SLOTS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN_DUP,
		ST_SCAN_FREE,
		ST_RELEASE,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [1:0]       func_q;
	logic [7:0]       code_q;
	logic [7:0]       usage_q;
	logic [1:0]       status_q;
	logic [7:0]       mod_q;
	logic [7:0]       slot_q [KEY_SLOTS];
	logic [IDX_W-1:0] idx_q;
	logic             map_vld_q [MAP_DEPTH];
	logic             vld_s1;
	logic             rpt_valid_q;
	hkrt_rpt_t        rpt_q;

	logic             accept;
	logic             map_we;
	logic [7:0]       map_rdata;
	logic [7:0]       entry;
	logic [7:0]       dec_usage;
	logic [7:0]       dec_mod;
	logic             dec_unmapped;
	logic [7:0]       mod_bit;
	logic [7:0]       cmp_op;
	logic             cmp_eq;
	logic             idx_last;
	logic [7:0]       slot_ext [EXT_N];

	assign accept = start && !busy;
	assign map_we = accept && (cmd.func == FUNC_MAP_WR);
	assign busy   = (state_q != ST_IDLE);

	hkrt_ram #(
		.WIDTH(8),
		.DEPTH(MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(cmd.map_index[MAP_AW-1:0]),
		.wdata(cmd.map_value),
		.raddr(cmd.key_code[MAP_AW-1:0]),
		.rdata(map_rdata)
	);

	always_comb begin
		entry        = vld_s1 ? map_rdata : 8'd0;
		mod_bit      = 8'd1 << code_q[2:0];
		dec_usage    = 8'd0;
		dec_mod      = mod_q;
		dec_unmapped = 1'b0;
		if (code_q >= RAW_BASE) begin
			dec_usage = code_q - RAW_BASE;
		end else if (code_q >= MOD_BASE) begin
			dec_mod = (func_q == FUNC_PRESS) ? (mod_q | mod_bit) : (mod_q & ~mod_bit);
		end else if (entry == 8'd0) begin
			dec_unmapped = 1'b1;
		end else begin
			dec_usage = entry & USAGE_MASK;
			if ((entry & SHIFT_FLAG) != 8'd0) begin
				dec_mod = (func_q == FUNC_PRESS) ? (mod_q | LEFT_SHIFT)
				                                 : (mod_q & ~LEFT_SHIFT);
			end
		end
	end

	assign cmp_op   = (state_q == ST_SCAN_FREE) ? 8'd0 : usage_q;
	assign cmp_eq   = (slot_q[idx_q] == cmp_op);
	assign idx_last = (idx_q == LAST_IDX);

	for (genvar g = 0; g < EXT_N; g++) begin : g_ext
		if (g < KEY_SLOTS) begin : g_real
			assign slot_ext[g] = slot_q[g];
		end else begin : g_pad
			assign slot_ext[g] = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			func_q      <= '0;
			code_q      <= '0;
			usage_q     <= '0;
			status_q    <= STAT_SENT;
			mod_q       <= 8'd0;
			idx_q       <= '0;
			rpt_valid_q <= 1'b0;
			rpt_q       <= '0;
			vld_s1      <= 1'b0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				slot_q[i] <= 8'd0;
			end
			for (int i = 0; i < MAP_DEPTH; i++) begin
				map_vld_q[i] <= 1'b0;
			end
		end else begin
			rpt_valid_q <= 1'b0;
			if (map_we) begin
				map_vld_q[cmd.map_index[MAP_AW-1:0]] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (cmd.func != FUNC_MAP_WR)) begin
						func_q  <= cmd.func;
						code_q  <= cmd.key_code;
						vld_s1  <= map_vld_q[cmd.key_code[MAP_AW-1:0]];
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					idx_q    <= '0;
					status_q <= STAT_SENT;
					if (func_q == FUNC_REL_ALL) begin
						mod_q <= 8'd0;
						for (int i = 0; i < KEY_SLOTS; i++) begin
							slot_q[i] <= 8'd0;
						end
						state_q <= ST_EMIT;
					end else if (dec_unmapped) begin
						status_q <= STAT_UNMAPPED;
						state_q  <= ST_EMIT;
					end else begin
						mod_q   <= dec_mod;
						usage_q <= dec_usage;
						if (func_q == FUNC_PRESS) begin
							state_q <= ST_SCAN_DUP;
						end else if (dec_usage == 8'd0) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_RELEASE;
						end
					end
				end
				ST_SCAN_DUP: begin
					if (cmp_eq) begin
						state_q <= ST_EMIT;
					end else if (idx_last) begin
						idx_q   <= '0;
						state_q <= ST_SCAN_FREE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SCAN_FREE: begin
					if (cmp_eq) begin
						slot_q[idx_q] <= usage_q;
						state_q       <= ST_EMIT;
					end else if (idx_last) begin
						status_q <= STAT_NO_SLOT;
						state_q  <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_RELEASE: begin
					if (cmp_eq) begin
						slot_q[idx_q] <= 8'd0;
					end
					if (idx_last) begin
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					rpt_valid_q         <= 1'b1;
					rpt_q.status        <= status_q;
					rpt_q.modifier_bits <= mod_q;
					rpt_q.slot0         <= slot_ext[0];
					rpt_q.slot1         <= slot_ext[1];
					rpt_q.slot2         <= slot_ext[2];
					rpt_q.slot3         <= slot_ext[3];
					rpt_q.slot4         <= slot_ext[4];
					rpt_q.slot5         <= slot_ext[5];
					state_q             <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

	a_emit_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |=> rpt_valid)
		else $error("report word not strobed after emit");

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid |=> !rpt_valid)
		else $error("report strobe longer than one cycle");

	a_map_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		map_we |=> !busy && !rpt_valid)
		else $error("map write started work or produced a report");

	a_start_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !map_we) |=> (state_q == ST_DECODE))
		else $error("accepted word did not enter decode");

	a_free_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_FREE && cmp_eq) |=>
		(slot_q[$past(idx_q)] == $past(usage_q)) && (status_q == STAT_SENT))
		else $error("free slot not filled with usage");

endmodule
